[sv/amp_pkg.sv]
// ----------------------------------------------------------------------------
// amp_pkg: shared types and constants for the amicable pair test
// Field widths of the ports, the output saturation limit and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package amp_pkg;

  // Width of each input number port.
  localparam int IN_W = 32;

  // Width of each divisor sum port and its saturation value.
  localparam int SUM_W = 36;
  localparam logic [SUM_W-1:0] SUM_FIELD_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_ADD_D,
    ST_ADD_Q,
    ST_STORE,
    ST_FINISH
  } amp_state_t;

endpackage

[sv/amp_div.sv]
// ----------------------------------------------------------------------------
// amp_div: iterative restoring divider
// Produces quotient and remainder of an unsigned division, one quotient bit
// per cycle. A start pulse while idle loads the operands; done pulses for
// one cycle when the results are ready, and they hold until the next start.
// ----------------------------------------------------------------------------
module amp_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  quo;
  logic [W-1:0]  quo_next;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // One restoring step: shift in the next dividend bit, try the subtract.
  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = shifted - {1'b0, dvs};
    if (diff[W]) begin
      rem_next = shifted[W-1:0];
      quo_next = {quo[W-2:0], 1'b0};
    end else begin
      rem_next = diff[W-1:0];
      quo_next = {quo[W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[sv/amicable_pair_test.sv]
// ----------------------------------------------------------------------------
// amicable_pair_test: aliquot sums of two numbers and amicable pair flag
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word holding first_number and
// second_number. Output channel (out_valid/out_ready) gives one word per
// input word: both aliquot sums (sum of proper divisors, 0 for 0 and 1) and
// is_amicable, set when each sum equals the other number.
// The numbers are handled one after the other by trial division. Each trial
// divisor d, from 2 while d*d <= n, goes through one shared serial divider,
// and when d divides n, d and its cofactor n/d are added to the sum, the
// cofactor only when it differs from d.
// in_ready is high only while no word is being worked on. A finished
// result waits in the output register, so the next word is taken while the
// receiver stalls; that word's result then waits until the register frees.
// Synchronous reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module amicable_pair_test #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [amp_pkg::IN_W-1:0]    first_number,
  input  logic [amp_pkg::IN_W-1:0]    second_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [amp_pkg::SUM_W-1:0]   first_divisor_sum,
  output logic [amp_pkg::SUM_W-1:0]   second_divisor_sum,
  output logic                        is_amicable
);

  localparam int W  = NUMBER_WIDTH;
  // An aliquot sum stays below sixteen times the number.
  localparam int SW = NUMBER_WIDTH + 4;
  localparam int EW = (SW > amp_pkg::SUM_W) ? SW : amp_pkg::SUM_W;

  amp_pkg::amp_state_t state;
  amp_pkg::amp_state_t state_next;

  logic [W+amp_pkg::IN_W-1:0] wide_a;
  logic [W+amp_pkg::IN_W-1:0] wide_b;
  logic [W-1:0]  num_a;
  logic [W-1:0]  num_b;
  logic [W-1:0]  cur;
  logic [W-1:0]  d;
  logic [W-1:0]  quotient;
  logic [W-1:0]  remainder;
  logic          sel;
  logic          div_start;
  logic          div_done;
  logic          out_free;
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_a;
  logic [SW-1:0] sum_b;
  logic [SW-1:0] add_val;
  logic [SW-1:0] sum_add;
  logic [EW-1:0] ext_a;
  logic [EW-1:0] ext_b;
  logic [amp_pkg::SUM_W-1:0] sat_a;
  logic [amp_pkg::SUM_W-1:0] sat_b;
  logic          hit;

  assign wide_a   = {{W{1'b0}}, first_number};
  assign wide_b   = {{W{1'b0}}, second_number};
  assign cur      = sel ? num_b : num_a;
  assign out_free = !out_valid || out_ready;

  // The single accumulator adder takes either the divisor or its cofactor.
  assign add_val = (state == amp_pkg::ST_ADD_Q) ? SW'(quotient) : SW'(d);
  assign sum_add = sum + add_val;

  assign ext_a = EW'(sum_a);
  assign ext_b = EW'(sum_b);
  assign sat_a = (ext_a > EW'(amp_pkg::SUM_FIELD_MAX)) ? amp_pkg::SUM_FIELD_MAX
                                                       : ext_a[amp_pkg::SUM_W-1:0];
  assign sat_b = (ext_b > EW'(amp_pkg::SUM_FIELD_MAX)) ? amp_pkg::SUM_FIELD_MAX
                                                       : ext_b[amp_pkg::SUM_W-1:0];
  assign hit   = (sum_a == SW'(num_b)) && (sum_b == SW'(num_a));

  amp_div #(
    .W (W)
  ) u_amp_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cur),
    .divisor   (d),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      amp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = amp_pkg::ST_LOAD;
      end
      amp_pkg::ST_LOAD: begin
        if (cur < W'(2)) state_next = amp_pkg::ST_STORE;
        else             state_next = amp_pkg::ST_START;
      end
      amp_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = amp_pkg::ST_WAIT;
      end
      amp_pkg::ST_WAIT: begin
        // The search ends once the cofactor drops below the trial divisor.
        if (div_done) begin
          if (quotient < d)            state_next = amp_pkg::ST_STORE;
          else if (remainder == '0)    state_next = amp_pkg::ST_ADD_D;
          else                         state_next = amp_pkg::ST_START;
        end
      end
      amp_pkg::ST_ADD_D: begin
        if (quotient != d) state_next = amp_pkg::ST_ADD_Q;
        else               state_next = amp_pkg::ST_START;
      end
      amp_pkg::ST_ADD_Q: begin
        state_next = amp_pkg::ST_START;
      end
      amp_pkg::ST_STORE: begin
        if (sel) state_next = amp_pkg::ST_FINISH;
        else     state_next = amp_pkg::ST_LOAD;
      end
      amp_pkg::ST_FINISH: begin
        if (out_free) state_next = amp_pkg::ST_IDLE;
      end
      default: begin
        state_next = amp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      case (state)
        amp_pkg::ST_IDLE: begin
          if (in_valid) begin
            num_a <= wide_a[W-1:0];
            num_b <= wide_b[W-1:0];
            sel   <= 1'b0;
          end
        end
        amp_pkg::ST_LOAD: begin
          sum <= (cur < W'(2)) ? SW'(0) : SW'(1);
          d   <= W'(2);
        end
        amp_pkg::ST_WAIT: begin
          if (div_done && !(quotient < d) && (remainder != '0)) d <= d + W'(1);
        end
        amp_pkg::ST_ADD_D: begin
          sum <= sum_add;
          if (quotient == d) d <= d + W'(1);
        end
        amp_pkg::ST_ADD_Q: begin
          sum <= sum_add;
          d   <= d + W'(1);
        end
        amp_pkg::ST_STORE: begin
          if (sel) begin
            sum_b <= sum;
          end else begin
            sum_a <= sum;
            sel   <= 1'b1;
          end
        end
        amp_pkg::ST_FINISH: begin
          if (out_free) begin
            first_divisor_sum  <= sat_a;
            second_divisor_sum <= sat_b;
            is_amicable        <= hit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == amp_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[sv/amp_checker.sv]
// ----------------------------------------------------------------------------
// amp_checker: port-level checks for the amicable pair test
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module amp_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [amp_pkg::IN_W-1:0]  first_number,
  input  logic [amp_pkg::IN_W-1:0]  second_number,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [amp_pkg::SUM_W-1:0] first_divisor_sum,
  input  logic [amp_pkg::SUM_W-1:0] second_divisor_sum,
  input  logic                      is_amicable
);

  // A result word that is stalled keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_divisor_sum)
      && $stable(second_divisor_sum) && $stable(is_amicable))
    else $error("stalled result word changed");

  // Reset leaves no result word pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // Once a word is taken, in_ready is low in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // Sums that match 32-bit numbers cannot reach the upper bits.
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_amicable |->
      first_divisor_sum[amp_pkg::SUM_W-1:amp_pkg::IN_W] == '0
      && second_divisor_sum[amp_pkg::SUM_W-1:amp_pkg::IN_W] == '0)
    else $error("amicable flag with out-of-range sum");

endmodule

bind amicable_pair_test amp_checker u_amp_checker (.*);

[test/tb_amicable_pair_test.sv]
// ----------------------------------------------------------------------------
// tb_amicable_pair_test: self-checking bench for the amicable pair test
// Sends pairs of numbers and compares every result word with sums computed
// here by trial division. Directed words cover zero and one, primes,
// squares, perfect numbers, known amicable pairs, near misses and the
// all-ones word. Random words follow: plain random numbers, known pairs,
// perfect numbers, near misses and numbers paired with their own aliquot
// sum. Both sides idle in random bursts, except in the last stretch of the run.
// ----------------------------------------------------------------------------
module tb_amicable_pair_test;

  localparam int IN_W  = amp_pkg::IN_W;
  localparam int SUM_W = amp_pkg::SUM_W;
  localparam logic [SUM_W-1:0] SUM_FIELD_MAX = amp_pkg::SUM_FIELD_MAX;

  localparam int QUIET_LIMIT  = 25_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 80;
  localparam int NPROBE       = 23;
  localparam int NFRIEND      = 10;

  class pair_sum_board;
    typedef struct {
      logic [SUM_W-1:0] first_sum;
      logic [SUM_W-1:0] second_sum;
      logic             amicable;
    } sums_t;

    sums_t pending[$];
    int    errors = 0;

    function longint unsigned aliquot_of(longint unsigned n);
      longint unsigned total;
      longint unsigned d;
      longint unsigned q;
      if (n < 2) return 0;
      total = 1;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) begin
          q = n / d;
          total += d;
          if (q != d) total += q;
        end
      end
      return total;
    endfunction

    function void note_pair(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
      longint unsigned sa;
      longint unsigned sb;
      sums_t s;
      sa = aliquot_of(a);
      sb = aliquot_of(b);
      // The flag is decided on the full sums, the ports saturate.
      s.amicable   = (sa == b) && (sb == a);
      s.first_sum  = (sa > SUM_FIELD_MAX) ? SUM_FIELD_MAX : sa[SUM_W-1:0];
      s.second_sum = (sb > SUM_FIELD_MAX) ? SUM_FIELD_MAX : sb[SUM_W-1:0];
      pending.push_back(s);
    endfunction

    function void check_sums(logic [SUM_W-1:0] fs, logic [SUM_W-1:0] ss, logic amic);
      sums_t s;
      if (pending.size() == 0) begin
        $error("unexpected result word: first_divisor_sum=%0d second_divisor_sum=%0d",
               fs, ss);
        errors++;
        return;
      end
      s = pending.pop_front();
      if (fs !== s.first_sum) begin
        $error("first_divisor_sum: expected %0d, actual %0d", s.first_sum, fs);
        errors++;
      end
      if (ss !== s.second_sum) begin
        $error("second_divisor_sum: expected %0d, actual %0d", s.second_sum, ss);
        errors++;
      end
      if (amic !== s.amicable) begin
        $error("is_amicable: expected %0b, actual %0b", s.amicable, amic);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IN_W-1:0]  first_number = '0;
  logic [IN_W-1:0]  second_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SUM_W-1:0] first_divisor_sum;
  logic [SUM_W-1:0] second_divisor_sum;
  logic             is_amicable;

  logic             jitter_on = 1'b1;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  pair_sum_board board = new;

  logic [IN_W-1:0] probe_first [NPROBE] = '{
    0, 0, 1, 1, 2, 4, 7, 6, 28, 496, 6, 220, 284, 220, 1184, 12285,
    17296, 63020, 8128, 33550336, 65537, 10744, 32'hFFFF_FFFF
  };
  logic [IN_W-1:0] probe_second [NPROBE] = '{
    0, 1, 0, 1, 3, 9, 1, 6, 28, 496, 28, 284, 220, 285, 1210, 14595,
    18416, 76084, 8128, 33550336, 2, 10857, 32'hFFFF_FFFF
  };

  logic [IN_W-1:0] friend_lo [NFRIEND] = '{
    220, 1184, 2620, 5020, 6232, 10744, 12285, 17296, 63020, 66928
  };
  logic [IN_W-1:0] friend_hi [NFRIEND] = '{
    284, 1210, 2924, 5564, 6368, 10856, 14595, 18416, 76084, 66992
  };
  logic [IN_W-1:0] perfect_nums [4] = '{6, 28, 496, 8128};

  amicable_pair_test dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .first_number       (first_number),
    .second_number      (second_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .first_divisor_sum  (first_divisor_sum),
    .second_divisor_sum (second_divisor_sum),
    .is_amicable        (is_amicable)
  );

  always #5 clk = ~clk;

  // Receiver: stalls come in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_sums(first_divisor_sum, second_divisor_sum, is_amicable);
  end

  // A single word of large numbers takes long to work through, so the limit
  // on quiet cycles is generous.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL amicable_pair_test");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    if (jitter_on && $urandom_range(0, 2) == 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    first_number  <= a;
    second_number <= b;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pair(a, b);
  endtask

  task automatic drain_results();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    int kind;
    int idx;
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    logic [IN_W-1:0] tmp;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NPROBE; k++)
      send_pair(probe_first[k], probe_second[k]);

    // Hold the sender back until the block has returned every word.
    in_valid <= 1'b0;
    @(posedge clk);
    drain_results();

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain_results();
      end
      if (k == RANDOM_WORDS - 20) jitter_on <= 1'b0;
      kind = $urandom_range(0, 99);
      idx  = $urandom_range(0, NFRIEND - 1);
      if (kind < 30) begin
        a = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
      end else if (kind < 50) begin
        a = friend_lo[idx];
        b = friend_hi[idx];
      end else if (kind < 60) begin
        a = perfect_nums[$urandom_range(0, 3)];
        b = ($urandom_range(0, 2) == 0) ? perfect_nums[$urandom_range(0, 3)] : a;
      end else if (kind < 70) begin
        // Near miss: one side of a known pair is nudged.
        a = $urandom_range(0, 1) ? friend_lo[idx] + $urandom_range(1, 2)
                                 : friend_lo[idx] - $urandom_range(1, 2);
        b = friend_hi[idx];
      end else if (kind < 90) begin
        a = $urandom_range(0, 4095);
        b = IN_W'(board.aliquot_of(a));
      end else begin
        a = $urandom_range(0, 262143);
        b = $urandom_range(0, 262143);
      end
      if ($urandom_range(0, 1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      send_pair(a, b);
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS amicable_pair_test");
    end else begin
      $display("FAIL amicable_pair_test");
    end
    $finish;
  end

endmodule
